>>> design/hit_miss_predictor_with_silencing_assert.svh
// ----------------------------------------------------------------------------
// Hit/miss predictor assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HIT_MISS_PREDICTOR_WITH_SILENCING_ASSERT_SVH
`define HIT_MISS_PREDICTOR_WITH_SILENCING_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HMP_ASSERT_IMP(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("hmp assertion failed");

// next-cycle implication
`define HMP_ASSERT_NXT(name, clock, reset, ante, cons) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("hmp assertion failed");

`else

`define HMP_ASSERT_IMP(name, clock, reset, ante, cons)
`define HMP_ASSERT_NXT(name, clock, reset, ante, cons)

`endif

`endif

>>> design/hmp_pkg.sv
// ----------------------------------------------------------------------------
// hmp_pkg
// Shared types and constants of the hit/miss predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hmp_pkg;

  // configuration port geometry
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 20;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_FALLBACK = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;

  // register reset values
  localparam logic               RST_ENABLE   = 1'b1;
  localparam logic               RST_FALLBACK = 1'b1;
  localparam logic [COUNT_W-1:0] RST_INTERVAL = 20'd1024;

  // item function codes
  localparam logic FUNC_PREDICT = 1'b0;
  localparam logic FUNC_UPDATE  = 1'b1;

  typedef struct packed {
    logic               enable;
    logic               fallback_present;
    logic [COUNT_W-1:0] interval;
  } cfg_t;

  // table memory controls
  typedef struct packed {
    logic rd_en;
    logic ctr_we;
    logic sil_we;
  } mem_ctl_t;

  typedef enum logic [2:0] {
    S_CLR_ALL,
    S_CLR_SIL,
    S_IDLE,
    S_INDEX,
    S_LOOK
  } state_e;

endpackage

>>> design/hmp_if.sv
// ----------------------------------------------------------------------------
// hmp_in_if / hmp_out_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hmp_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] addr;
  logic        actual_hit;
  logic        fallback_prediction;

  modport source (output valid, func, addr, actual_hit, fallback_prediction, input ready);
  modport sink   (input valid, func, addr, actual_hit, fallback_prediction, output ready);
endinterface

interface hmp_out_if;
  logic       valid;
  logic       ready;
  logic       prediction;
  logic       used_fallback;
  logic [1:0] counter_now;
  logic       silenced_now;

  modport source (output valid, prediction, used_fallback, counter_now, silenced_now,
                  input ready);
  modport sink   (input valid, prediction, used_fallback, counter_now, silenced_now,
                  output ready);
endinterface

>>> design/hmp_cfg.sv
// ----------------------------------------------------------------------------
// hmp_cfg
// APB register file: enable, fallback_present, silence_reset_interval.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmp_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hmp_pkg::ADDR_W-1:0] paddr,
  input  logic [hmp_pkg::DATA_W-1:0] pwdata,
  output logic [hmp_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output hmp_pkg::cfg_t              cfg
);
  import hmp_pkg::*;

  logic       wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable           <= RST_ENABLE;
      cfg.fallback_present <= RST_FALLBACK;
      cfg.interval         <= RST_INTERVAL;
    end else if (wr) begin
      unique case (reg_idx)
        REG_ENABLE:   cfg.enable           <= pwdata[0];
        REG_FALLBACK: cfg.fallback_present <= pwdata[0];
        REG_INTERVAL: cfg.interval         <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_ENABLE:   prdata = {{(DATA_W-1){1'b0}}, cfg.enable};
      REG_FALLBACK: prdata = {{(DATA_W-1){1'b0}}, cfg.fallback_present};
      REG_INTERVAL: prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg.interval};
      default:      prdata = '0;
    endcase
  end

endmodule

>>> design/hmp_index.sv
// ----------------------------------------------------------------------------
// hmp_index
// Table index from a word address: (addr >> 2) mod TABLE_ENTRIES.
// Power-of-two sizes take a bit slice; others run a remainder unit,
// eight address bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmp_index #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int IDX_W         = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [63:0]      addr,
  output logic [IDX_W-1:0] idx,
  output logic             done
);

  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  generate
    if (IS_POW2) begin : g_slice
      logic [IDX_W-1:0] idx_q;

      // latch slice; done follows in the next cycle
      always_ff @(posedge clk) begin
        if (start) idx_q <= addr[IDX_W+1:2];
      end

      always_ff @(posedge clk) begin
        if (rst) done <= 1'b0;
        else     done <= start;
      end

      assign idx = idx_q;
    end else begin : g_mod
      localparam int                 STEP   = 8;
      localparam int                 STEPS  = 64 / STEP;
      localparam int                 CNT_W  = $clog2(STEPS);
      localparam logic [IDX_W:0]     MODV   = (IDX_W+1)'(TABLE_ENTRIES);
      localparam logic [CNT_W-1:0]   LAST   = CNT_W'(STEPS - 1);

      logic [63:0]      shreg;
      logic [IDX_W-1:0] rem;
      logic [IDX_W:0]   rem_step;
      logic [CNT_W-1:0] cnt;
      logic             busy;

      // eight restoring steps: r = 2r + bit, subtract modulus if over
      always_comb begin
        logic [IDX_W:0] r;
        r = {1'b0, rem};
        for (int k = 0; k < STEP; k++) begin
          r = {r[IDX_W-1:0], shreg[63-k]};
          if (r >= MODV) r = r - MODV;
        end
        rem_step = r;
      end

      // datapath
      always_ff @(posedge clk) begin
        if (start) begin
          shreg <= {2'b00, addr[63:2]};
          rem   <= '0;
        end else if (busy) begin
          shreg <= shreg << STEP;
          rem   <= rem_step[IDX_W-1:0];
        end
      end

      // control
      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          cnt  <= '0;
          done <= 1'b0;
        end else begin
          done <= 1'b0;
          if (start) begin
            busy <= 1'b1;
            cnt  <= '0;
          end else if (busy) begin
            cnt <= cnt + CNT_W'(1);
            if (cnt == LAST) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        end
      end

      assign idx = rem;
    end
  endgenerate

endmodule

>>> design/hmp_table.sv
// ----------------------------------------------------------------------------
// hmp_table
// Counter and silence-bit memories, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hmp_table #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10,
  parameter int CTR_W = 2
) (
  input  logic                clk,
  input  hmp_pkg::mem_ctl_t   ctl,
  input  logic [IDX_W-1:0]    rd_idx,
  input  logic [IDX_W-1:0]    wr_idx,
  input  logic [CTR_W-1:0]    wr_ctr,
  input  logic                wr_sil,
  output logic [CTR_W-1:0]    rd_ctr,
  output logic                rd_sil
);
  import hmp_pkg::*;

  logic [CTR_W-1:0] ctr_mem [DEPTH];
  logic             sil_mem [DEPTH];

  // write ports
  always_ff @(posedge clk) begin
    if (ctl.ctr_we) ctr_mem[wr_idx] <= wr_ctr;
    if (ctl.sil_we) sil_mem[wr_idx] <= wr_sil;
  end

  // registered read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_ctr <= ctr_mem[rd_idx];
      rd_sil <= sil_mem[rd_idx];
    end
  end

endmodule

>>> design/hmp_core.sv
// ----------------------------------------------------------------------------
// hmp_core
// Sequencer: clearing sweeps, index wait, table read-modify-write, result
// register and the update interval count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hit_miss_predictor_with_silencing_assert.svh"

module hmp_core #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int COUNTER_MAX   = 3,
  parameter int IDX_W         = 10,
  parameter int CTR_W         = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  hmp_pkg::cfg_t     cfg,
  hmp_in_if.sink            in_ch,
  hmp_out_if.source         out_ch,
  output logic              idx_start,
  input  logic              idx_done,
  input  logic [IDX_W-1:0]  idx,
  output hmp_pkg::mem_ctl_t mem_ctl,
  output logic [IDX_W-1:0]  rd_idx,
  output logic [IDX_W-1:0]  wr_idx,
  output logic [CTR_W-1:0]  wr_ctr,
  output logic              wr_sil,
  input  logic [CTR_W-1:0]  rd_ctr,
  input  logic              rd_sil
);
  import hmp_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CTR_W-1:0] CTR_MAX  = CTR_W'(COUNTER_MAX);
  localparam logic [CTR_W-1:0] CTR_HALF = CTR_W'(COUNTER_MAX / 2);
  localparam logic [CTR_W-1:0] CTR_THR  = CTR_W'(COUNTER_MAX / 2 + 1);
  localparam logic [CTR_W-1:0] CTR_ONE  = CTR_W'(1);

  state_e state, state_next;

  logic [IDX_W-1:0]   sweep_idx;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_inc;
  logic               func_q, hit_q, fb_q;
  logic [IDX_W-1:0]   idx_q;

  logic               accept, finish;
  logic               upd_active, upd_wr, sil_set, clr_hit;
  logic [CTR_W-1:0]   ctr_new, ctr_out;
  logic [CTR_W+1:0]   ctr_ext;
  logic               pred_new, sil_out;

  logic               out_valid;
  logic               pred_q, used_q, sil_now_q;
  logic [1:0]         ctr_now_q;

  function automatic logic at_rail(input logic [CTR_W-1:0] c);
    return (c == '0) || (c == CTR_MAX);
  endfunction

  assign accept = in_ch.valid && in_ch.ready;
  assign finish = (state == S_LOOK) && (!out_valid || out_ch.ready);

  // ---- update arithmetic on the entry just read
  assign upd_active = cfg.enable && (func_q == FUNC_UPDATE);
  assign upd_wr     = upd_active && !rd_sil;
  assign count_inc  = count + COUNT_W'(1);
  assign clr_hit    = count_inc >= cfg.interval;

  always_comb begin
    if (hit_q) ctr_new = (rd_ctr != CTR_MAX) ? rd_ctr + CTR_ONE : rd_ctr;
    else       ctr_new = (rd_ctr != '0)      ? rd_ctr - CTR_ONE : rd_ctr;
  end

  // leaving a rail for a middle value silences the entry
  assign sil_set = at_rail(rd_ctr) && !at_rail(ctr_new);

  // ---- result fields
  always_comb begin
    pred_new = 1'b0;
    if (cfg.enable && func_q == FUNC_PREDICT) begin
      if (rd_sil) pred_new = cfg.fallback_present && fb_q;
      else        pred_new = rd_ctr >= CTR_THR;
    end
  end

  assign ctr_out = upd_wr ? ctr_new : rd_ctr;
  assign ctr_ext = {2'b00, ctr_out};

  always_comb begin
    if (upd_active && clr_hit) sil_out = 1'b0;
    else                       sil_out = rd_sil || (upd_wr && sil_set);
  end

  // ---- next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR_ALL, S_CLR_SIL: if (sweep_idx == LAST_IDX) state_next = S_IDLE;
      S_IDLE:               if (accept) state_next = S_INDEX;
      S_INDEX:              if (idx_done) state_next = S_LOOK;
      S_LOOK: begin
        if (finish) state_next = (upd_active && clr_hit) ? S_CLR_SIL : S_IDLE;
      end
      default:              state_next = S_CLR_ALL;
    endcase
  end

  // ---- state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    mem_ctl     = '0;
    wr_idx      = idx_q;
    wr_ctr      = ctr_new;
    wr_sil      = 1'b1;
    unique case (state)
      S_CLR_ALL: begin
        mem_ctl.ctr_we = 1'b1;
        mem_ctl.sil_we = 1'b1;
        wr_idx         = sweep_idx;
        wr_ctr         = CTR_HALF;
        wr_sil         = 1'b0;
      end
      S_CLR_SIL: begin
        mem_ctl.sil_we = 1'b1;
        wr_idx         = sweep_idx;
        wr_sil         = 1'b0;
      end
      S_IDLE:  in_ch.ready = 1'b1;
      S_INDEX: mem_ctl.rd_en = idx_done;
      S_LOOK: begin
        mem_ctl.ctr_we = finish && upd_wr;
        mem_ctl.sil_we = finish && upd_wr && sil_set;
      end
      default: ;
    endcase
  end

  assign idx_start = accept;
  assign rd_idx    = idx;

  // ---- state, sweep pointer, interval count
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR_ALL;
      sweep_idx <= '0;
      count     <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLR_ALL || state == S_CLR_SIL) begin
        sweep_idx <= (sweep_idx == LAST_IDX) ? '0 : sweep_idx + IDX_W'(1);
      end
      if (finish && upd_active) count <= clr_hit ? '0 : count_inc;
    end
  end

  // ---- item fields
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= in_ch.func;
      hit_q  <= in_ch.actual_hit;
      fb_q   <= in_ch.fallback_prediction;
    end
    if (idx_done) idx_q <= idx;
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      pred_q    <= pred_new;
      used_q    <= cfg.enable && rd_sil;
      ctr_now_q <= ctr_ext[1:0];
      sil_now_q <= sil_out;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.prediction    = pred_q;
  assign out_ch.used_fallback = used_q;
  assign out_ch.counter_now   = ctr_now_q;
  assign out_ch.silenced_now  = sil_now_q;

  // ---- assertions
  `HMP_ASSERT_NXT(a_accept_to_index, clk, rst, accept, state == S_INDEX)
  `HMP_ASSERT_IMP(a_ctr_we_legal, clk, rst, mem_ctl.ctr_we, state == S_CLR_ALL || state == S_LOOK)
  `HMP_ASSERT_NXT(a_interval_clear, clk, rst, finish && upd_active && clr_hit, state == S_CLR_SIL)
  `HMP_ASSERT_IMP(a_sweep_from_zero, clk, rst, state == S_CLR_SIL && $past(state) == S_LOOK, sweep_idx == '0)

endmodule

>>> design/hit_miss_predictor_with_silencing.sv
// ----------------------------------------------------------------------------
// hit_miss_predictor_with_silencing
// Load hit/miss predictor: saturating counters with per-entry silence bits.
//
//   channel  | dir | handshake        | word
//   ---------+-----+------------------+---------------------------------------
//   in_ch    | in  | valid/ready      | func, addr, actual_hit, fallback_pred.
//   out_ch   | out | valid/ready      | prediction, used_fallback,
//            |     |                  | counter_now, silenced_now
//   apb      | in  | psel/penable     | paddr, pwdata, prdata (pready = 1)
//
// An item passes accept, index, a registered table read and write-back when
// TABLE_ENTRIES is a power of two; otherwise the remainder unit runs its
// steps between accept and the table read.
// After reset, a clearing pass writes every entry.
// An update that reaches the interval starts a pass that clears the silence
// bits; no word is taken during either pass.
// A result waits in the output register; the next word is taken meanwhile,
// and write-back holds while that register is full and not taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hit_miss_predictor_with_silencing #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int COUNTER_MAX   = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  hmp_in_if.sink                     in_ch,
  hmp_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hmp_pkg::ADDR_W-1:0] paddr,
  input  logic [hmp_pkg::DATA_W-1:0] pwdata,
  output logic [hmp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import hmp_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CTR_W = $clog2(COUNTER_MAX + 1);

  cfg_t             cfg;
  mem_ctl_t         mem_ctl;
  logic             idx_start, idx_done;
  logic [IDX_W-1:0] idx, rd_idx, wr_idx;
  logic [CTR_W-1:0] wr_ctr, rd_ctr;
  logic             wr_sil, rd_sil;

  hmp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hmp_index #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_index (
    .clk   (clk),
    .rst   (rst),
    .start (idx_start),
    .addr  (in_ch.addr),
    .idx   (idx),
    .done  (idx_done)
  );

  hmp_table #(
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W),
    .CTR_W (CTR_W)
  ) u_table (
    .clk    (clk),
    .ctl    (mem_ctl),
    .rd_idx (rd_idx),
    .wr_idx (wr_idx),
    .wr_ctr (wr_ctr),
    .wr_sil (wr_sil),
    .rd_ctr (rd_ctr),
    .rd_sil (rd_sil)
  );

  hmp_core #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNTER_MAX   (COUNTER_MAX),
    .IDX_W         (IDX_W),
    .CTR_W         (CTR_W)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .idx_start (idx_start),
    .idx_done  (idx_done),
    .idx       (idx),
    .mem_ctl   (mem_ctl),
    .rd_idx    (rd_idx),
    .wr_idx    (wr_idx),
    .wr_ctr    (wr_ctr),
    .wr_sil    (wr_sil),
    .rd_ctr    (rd_ctr),
    .rd_sil    (rd_sil)
  );

endmodule
